### rtl/core/vrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_pkg
// Shared types, register indexes and reset values for the vertex rotate and
// project core.
// ----------------------------------------------------------------------------
package vrp_pkg;

    localparam int FRAC_BITS   = 8;
    localparam int TRIG_FRAC   = 14;
    localparam int TRIG_W      = 16;
    localparam int WHOLE_W     = 16;
    localparam int WHOLE_Q8_W  = WHOLE_W + FRAC_BITS;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 48;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ROT_X = 3'd0,
        CFG_ROT_Y = 3'd1,
        CFG_ROT_Z = 3'd2,
        CFG_PIVOT = 3'd3,
        CFG_EYE   = 3'd4
    } cfg_index_t;

    // Cosine sits in the upper half of the register word.
    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_q;
        logic signed [TRIG_W-1:0] sin_q;
    } trig_t;

    // Whole-unit point, x in the upper bits.
    typedef struct packed {
        logic signed [WHOLE_W-1:0] x;
        logic signed [WHOLE_W-1:0] y;
        logic signed [WHOLE_W-1:0] z;
    } vec3_t;

    typedef struct packed {
        logic sat;
        logic fault;
        logic neg_x;
        logic neg_y;
    } proj_flags_t;

    localparam logic [31:0] ROT_TRIG_RESET = 32'h3F7F_0805;
    localparam logic [47:0] PIVOT_RESET    = 48'h0000_0032_003C;
    localparam logic [47:0] EYE_RESET      = 48'h0000_0000_FF9C;

    function automatic logic signed [WHOLE_Q8_W-1:0] to_q8(input logic signed [WHOLE_W-1:0] v);
        return $signed({v, {FRAC_BITS{1'b0}}});
    endfunction

endpackage

### rtl/core/vertex_rotate_project_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_rotate_project_core
// Rotates a vertex about a pivot (X, then Y, then Z) and projects it from an
// eye point onto the z=0 plane.
// ----------------------------------------------------------------------------
// Stages: one input stage, two per rotation, four for projection set-up,
// COORD_WIDTH + 26 divider stages (one quotient bit each) and the output buffer.
// Throughput: one vertex per cycle while the output buffer is not full; a
// two-entry output buffer decouples the sides.
// Reset clears all valid state and loads the default rotation, pivot and eye.
module vertex_rotate_project_core
    import vrp_pkg::*;
#(
    parameter int COORD_WIDTH = 24
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0]                 cfg_index,
    input  logic [CFG_DATA_W-1:0]                  cfg_data,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // vx, vy, vz from the lowest bit up
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // rx, ry, rz, proj_x, proj_y from the lowest bit up
    output logic [((5*COORD_WIDTH+7)/8)*8-1:0]     m_tdata,
    // divide_fault, saturated from the lowest bit up
    output logic [1:0]                             m_tuser
);

    localparam int W     = COORD_WIDTH;
    localparam int AW    = ((W > WHOLE_Q8_W) ? W : WHOLE_Q8_W) + 1;
    localparam int DEN_W = AW;
    localparam int MAG_W = W + WHOLE_Q8_W + 2;
    localparam int IW2   = AW + 3;
    localparam int IW3   = AW + 6;
    localparam int XW    = AW + 9;
    localparam int PAYW  = 3 * W + $bits(proj_flags_t);

    trig_t rot_x_reg, rot_y_reg, rot_z_reg;
    vec3_t pivot_reg, eye_reg;

    logic en;
    logic signed [AW-1:0] x0_reg, y0_reg, z0_reg;
    logic vld0_reg;

    logic               vld1;
    logic signed [IW2-1:0] y1, z1;
    logic [AW-1:0]      x0_pass;
    logic signed [IW2-1:0] x0_ext;

    logic               vld2;
    logic signed [IW3-1:0] z2, x2;
    logic [IW2-1:0]     y1_pass;
    logic signed [IW3-1:0] y1_ext;

    logic               vld3;
    logic signed [XW-1:0] x3, y3;
    logic [IW3-1:0]     z2_pass;

    logic               vld4;
    logic signed [W-1:0] rx, ry, rz;
    logic [MAG_W-1:0]   mag_x, mag_y;
    logic [DEN_W-1:0]   dvs;
    proj_flags_t        flags;

    logic               vld5;
    logic [MAG_W-1:0]   quo_x, quo_y;
    logic [PAYW-1:0]    pay_out;
    proj_flags_t        flags5;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_x_reg <= trig_t'(ROT_TRIG_RESET);
            rot_y_reg <= trig_t'(ROT_TRIG_RESET);
            rot_z_reg <= trig_t'(ROT_TRIG_RESET);
            pivot_reg <= vec3_t'(PIVOT_RESET);
            eye_reg   <= vec3_t'(EYE_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_ROT_X: rot_x_reg <= trig_t'(cfg_data[31:0]);
                CFG_ROT_Y: rot_y_reg <= trig_t'(cfg_data[31:0]);
                CFG_ROT_Z: rot_z_reg <= trig_t'(cfg_data[31:0]);
                CFG_PIVOT: pivot_reg <= vec3_t'(cfg_data);
                CFG_EYE:   eye_reg   <= vec3_t'(cfg_data);
                default:   ;
            endcase
        end
    end

    assign s_tready = en;

    // Input stage: move the vertex into pivot-relative coordinates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
        end
        else if (en)
        begin
            vld0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg <= AW'($signed(s_tdata[0 +: W])) - AW'(to_q8(pivot_reg.x));
            y0_reg <= AW'($signed(s_tdata[W +: W])) - AW'(to_q8(pivot_reg.y));
            z0_reg <= AW'($signed(s_tdata[2*W +: W])) - AW'(to_q8(pivot_reg.z));
        end
    end

    vrp_rotate #(.IW(AW), .PW(AW)) u_rot_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld0_reg),
        .trig      (rot_x_reg),
        .a         (y0_reg),
        .b         (z0_reg),
        .pass_in   (x0_reg),
        .out_valid (vld1),
        .a_rot     (y1),
        .b_rot     (z1),
        .pass_out  (x0_pass)
    );

    assign x0_ext = IW2'($signed(x0_pass));

    // About Y the pair is ordered (z, x) so the same rotation form applies.
    vrp_rotate #(.IW(IW2), .PW(IW2)) u_rot_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld1),
        .trig      (rot_y_reg),
        .a         (z1),
        .b         (x0_ext),
        .pass_in   (y1),
        .out_valid (vld2),
        .a_rot     (z2),
        .b_rot     (x2),
        .pass_out  (y1_pass)
    );

    assign y1_ext = IW3'($signed(y1_pass));

    vrp_rotate #(.IW(IW3), .PW(IW3)) u_rot_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld2),
        .trig      (rot_z_reg),
        .a         (x2),
        .b         (y1_ext),
        .pass_in   (z2),
        .out_valid (vld3),
        .a_rot     (x3),
        .b_rot     (y3),
        .pass_out  (z2_pass)
    );

    vrp_project #(.COORD_WIDTH(W), .XW(XW)) u_project (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld3),
        .x         (x3),
        .y         (y3),
        .z         (XW'($signed(z2_pass))),
        .pivot     (pivot_reg),
        .eye       (eye_reg),
        .out_valid (vld4),
        .rx        (rx),
        .ry        (ry),
        .rz        (rz),
        .mag_x     (mag_x),
        .mag_y     (mag_y),
        .dvs       (dvs),
        .flags     (flags)
    );

    vrp_divider #(.NB(MAG_W), .DW(DEN_W), .PAYW(PAYW)) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld4),
        .num_x     (mag_x),
        .num_y     (mag_y),
        .dvs       (dvs),
        .pay_in    ({rz, ry, rx, flags}),
        .out_valid (vld5),
        .quo_x     (quo_x),
        .quo_y     (quo_y),
        .pay_out   (pay_out)
    );

    assign flags5 = proj_flags_t'(pay_out[$bits(proj_flags_t)-1:0]);

    vrp_result #(.COORD_WIDTH(W), .NB(MAG_W)) u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld5),
        .quo_x     (quo_x),
        .quo_y     (quo_y),
        .rx        (pay_out[$bits(proj_flags_t) +: W]),
        .ry        (pay_out[$bits(proj_flags_t) + W +: W]),
        .rz        (pay_out[$bits(proj_flags_t) + 2*W +: W]),
        .flags     (flags5),
        .advance   (en),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

### rtl/core/vrp_rotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_rotate
// Two-stage planar rotation: a' = a*c - b*s, b' = a*s + b*c, rounded half up
// from Q.22 to Q.8. A third coordinate rides along unchanged.
// ----------------------------------------------------------------------------
module vrp_rotate
    import vrp_pkg::*;
#(
    parameter int IW = 25,
    parameter int PW = 25
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  trig_t                trig,
    input  logic signed [IW-1:0] a,
    input  logic signed [IW-1:0] b,
    input  logic [PW-1:0]        pass_in,
    output logic                 out_valid,
    output logic signed [IW+2:0] a_rot,
    output logic signed [IW+2:0] b_rot,
    output logic [PW-1:0]        pass_out
);

    localparam int PRW = IW + TRIG_W;
    localparam int SW  = PRW + 1;
    localparam logic signed [SW-1:0] HALF = SW'(2 ** (TRIG_FRAC - 1));

    logic signed [TRIG_W-1:0] c_q;
    logic signed [TRIG_W-1:0] s_q;
    logic signed [PRW-1:0] ac_reg, bs_reg, as_reg, bc_reg;
    logic signed [PRW-1:0] ac_next, bs_next, as_next, bc_next;
    logic [PW-1:0] pass1_reg;
    logic vld1_reg;
    logic signed [SW-1:0] a_sum, b_sum;
    logic signed [IW+2:0] a_rot_reg, b_rot_reg;
    logic signed [IW+2:0] a_rot_next, b_rot_next;
    logic [PW-1:0] pass2_reg;
    logic vld2_reg;

    assign c_q = trig.cos_q;
    assign s_q = trig.sin_q;

    always_comb
    begin
        ac_next = a * c_q;
        bs_next = b * s_q;
        as_next = a * s_q;
        bc_next = b * c_q;
    end

    always_comb
    begin
        a_sum = SW'(ac_reg) - SW'(bs_reg) + HALF;
        b_sum = SW'(as_reg) + SW'(bc_reg) + HALF;
        // Dropping the fraction bits of a two's complement value is a floor.
        a_rot_next = a_sum[SW-1:TRIG_FRAC];
        b_rot_next = b_sum[SW-1:TRIG_FRAC];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ac_reg    <= ac_next;
            bs_reg    <= bs_next;
            as_reg    <= as_next;
            bc_reg    <= bc_next;
            pass1_reg <= pass_in;
            a_rot_reg <= a_rot_next;
            b_rot_reg <= b_rot_next;
            pass2_reg <= pass1_reg;
        end
    end

    assign out_valid = vld2_reg;
    assign a_rot     = a_rot_reg;
    assign b_rot     = b_rot_reg;
    assign pass_out  = pass2_reg;

endmodule

### rtl/core/vrp_project.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_project
// Adds the pivot back and clamps, forms the projection numerators and the
// denominator, and hands rounded-up magnitudes and signs to the divider.
// ----------------------------------------------------------------------------
module vrp_project
    import vrp_pkg::*;
#(
    parameter int COORD_WIDTH = 24,
    parameter int XW          = 34
)
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       en,
    input  logic                                       in_valid,
    input  logic signed [XW-1:0]                       x,
    input  logic signed [XW-1:0]                       y,
    input  logic signed [XW-1:0]                       z,
    input  vec3_t                                      pivot,
    input  vec3_t                                      eye,
    output logic                                       out_valid,
    output logic signed [COORD_WIDTH-1:0]              rx,
    output logic signed [COORD_WIDTH-1:0]              ry,
    output logic signed [COORD_WIDTH-1:0]              rz,
    output logic [COORD_WIDTH+WHOLE_Q8_W+1:0]          mag_x,
    output logic [COORD_WIDTH+WHOLE_Q8_W+1:0]          mag_y,
    output logic [((COORD_WIDTH > WHOLE_Q8_W) ? COORD_WIDTH : WHOLE_Q8_W):0] dvs,
    output proj_flags_t                                flags
);

    localparam int W     = COORD_WIDTH;
    localparam int SW    = XW + 1;
    localparam int PRW   = W + WHOLE_Q8_W;
    localparam int NUM_W = PRW + 1;
    localparam int MAG_W = NUM_W + 1;
    localparam int DEN_W = ((W > WHOLE_Q8_W) ? W : WHOLE_Q8_W) + 1;

    logic signed [XW-1:0] coord [3];
    logic signed [WHOLE_Q8_W-1:0] piv_q8 [3];
    logic signed [SW-1:0] sum;
    logic signed [W-1:0] r_next [3];
    logic sat_next;
    logic signed [WHOLE_Q8_W-1:0] ex_q8, ey_q8, ez_q8;

    // Stage 0: rotated point with pivot restored, clamped.
    logic signed [W-1:0] r0_reg [3];
    logic sat0_reg, vld0_reg;
    // Stage 1: products and denominator.
    logic signed [PRW-1:0] zex_reg, xez_reg, zey_reg, yez_reg;
    logic signed [DEN_W-1:0] den1_reg;
    logic signed [W-1:0] r1_reg [3];
    logic sat1_reg, vld1_reg;
    // Stage 2: numerators.
    logic signed [NUM_W-1:0] nx_reg, ny_reg;
    logic signed [DEN_W-1:0] den2_reg;
    logic signed [W-1:0] r2_reg [3];
    logic sat2_reg, vld2_reg;
    // Stage 3: magnitudes for the divider.
    logic [NUM_W-1:0] an_x, an_y;
    logic [DEN_W-1:0] ad;
    logic [MAG_W-1:0] mag_x_reg, mag_y_reg;
    logic [DEN_W-1:0] dvs_reg;
    logic signed [W-1:0] r3_reg [3];
    proj_flags_t flags_reg;
    logic vld3_reg;

    assign coord[0]  = x;
    assign coord[1]  = y;
    assign coord[2]  = z;
    assign piv_q8[0] = to_q8(pivot.x);
    assign piv_q8[1] = to_q8(pivot.y);
    assign piv_q8[2] = to_q8(pivot.z);
    assign ex_q8     = to_q8(eye.x);
    assign ey_q8     = to_q8(eye.y);
    assign ez_q8     = to_q8(eye.z);

    always_comb
    begin
        sum      = '0;
        sat_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            sum = SW'(coord[i]) + SW'(piv_q8[i]);
            // The value fits when every bit from the sign of the result up agrees.
            if ((&sum[SW-1:W-1]) || !(|sum[SW-1:W-1]))
            begin
                r_next[i] = sum[W-1:0];
            end
            else
            begin
                sat_next  = 1'b1;
                r_next[i] = sum[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end
        end
    end

    always_comb
    begin
        an_x = nx_reg[NUM_W-1] ? NUM_W'(-nx_reg) : NUM_W'(nx_reg);
        an_y = ny_reg[NUM_W-1] ? NUM_W'(-ny_reg) : NUM_W'(ny_reg);
        ad   = den2_reg[DEN_W-1] ? DEN_W'(-den2_reg) : DEN_W'(den2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (en)
        begin
            vld0_reg <= in_valid;
            vld1_reg <= vld0_reg;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r0_reg   <= r_next;
            sat0_reg <= sat_next;

            zex_reg  <= r0_reg[2] * ex_q8;
            xez_reg  <= r0_reg[0] * ez_q8;
            zey_reg  <= r0_reg[2] * ey_q8;
            yez_reg  <= r0_reg[1] * ez_q8;
            den1_reg <= DEN_W'(r0_reg[2]) - DEN_W'(ez_q8);
            r1_reg   <= r0_reg;
            sat1_reg <= sat0_reg;

            nx_reg   <= NUM_W'(zex_reg) - NUM_W'(xez_reg);
            ny_reg   <= NUM_W'(zey_reg) - NUM_W'(yez_reg);
            den2_reg <= den1_reg;
            r2_reg   <= r1_reg;
            sat2_reg <= sat1_reg;

            // Adding half the divisor turns the truncating divide into
            // round to nearest, ties away from zero.
            mag_x_reg       <= MAG_W'(an_x) + MAG_W'(ad[DEN_W-1:1]);
            mag_y_reg       <= MAG_W'(an_y) + MAG_W'(ad[DEN_W-1:1]);
            dvs_reg         <= ad;
            r3_reg          <= r2_reg;
            flags_reg.sat   <= sat2_reg;
            flags_reg.fault <= (den2_reg == '0);
            flags_reg.neg_x <= nx_reg[NUM_W-1] ^ den2_reg[DEN_W-1];
            flags_reg.neg_y <= ny_reg[NUM_W-1] ^ den2_reg[DEN_W-1];
        end
    end

    assign out_valid = vld3_reg;
    assign rx        = r3_reg[0];
    assign ry        = r3_reg[1];
    assign rz        = r3_reg[2];
    assign mag_x     = mag_x_reg;
    assign mag_y     = mag_y_reg;
    assign dvs       = dvs_reg;
    assign flags     = flags_reg;

endmodule

### rtl/core/vrp_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_divider
// Pipelined restoring divider, one quotient bit per stage, with two lanes
// that share one divisor. A payload travels alongside.
// ----------------------------------------------------------------------------
module vrp_divider
    import vrp_pkg::*;
#(
    parameter int NB   = 50,
    parameter int DW   = 25,
    parameter int PAYW = 76
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [NB-1:0]   num_x,
    input  logic [NB-1:0]   num_y,
    input  logic [DW-1:0]   dvs,
    input  logic [PAYW-1:0] pay_in,
    output logic            out_valid,
    output logic [NB-1:0]   quo_x,
    output logic [NB-1:0]   quo_y,
    output logic [PAYW-1:0] pay_out
);

    logic [DW-1:0]   rem_x_reg [NB];
    logic [DW-1:0]   rem_y_reg [NB];
    logic [NB-1:0]   quo_x_reg [NB];
    logic [NB-1:0]   quo_y_reg [NB];
    logic [DW-1:0]   dvs_reg   [NB];
    logic [PAYW-1:0] pay_reg   [NB];
    logic            vld_reg   [NB];

    logic [DW-1:0]   rem_x_next [NB];
    logic [DW-1:0]   rem_y_next [NB];
    logic [NB-1:0]   quo_x_next [NB];
    logic [NB-1:0]   quo_y_next [NB];

    logic [DW-1:0] rx_src, ry_src, d_src;
    logic [NB-1:0] qx_src, qy_src;
    logic [DW:0]   t_x, t_y, d_ext, diff_x, diff_y;
    logic          ge_x, ge_y;

    always_comb
    begin
        for (int s = 0; s < NB; s++)
        begin
            if (s == 0)
            begin
                rx_src = '0;
                ry_src = '0;
                qx_src = num_x;
                qy_src = num_y;
                d_src  = dvs;
            end
            else
            begin
                rx_src = rem_x_reg[s-1];
                ry_src = rem_y_reg[s-1];
                qx_src = quo_x_reg[s-1];
                qy_src = quo_y_reg[s-1];
                d_src  = dvs_reg[s-1];
            end
            // The dividend shifts out of the top of the quotient word while
            // quotient bits enter at the bottom.
            t_x    = {rx_src, qx_src[NB-1]};
            t_y    = {ry_src, qy_src[NB-1]};
            d_ext  = {1'b0, d_src};
            ge_x   = (t_x >= d_ext);
            ge_y   = (t_y >= d_ext);
            diff_x = t_x - d_ext;
            diff_y = t_y - d_ext;
            rem_x_next[s] = ge_x ? diff_x[DW-1:0] : t_x[DW-1:0];
            rem_y_next[s] = ge_y ? diff_y[DW-1:0] : t_y[DW-1:0];
            quo_x_next[s] = {qx_src[NB-2:0], ge_x};
            quo_y_next[s] = {qy_src[NB-2:0], ge_y};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NB; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s < NB; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dvs_reg[0] <= dvs;
            pay_reg[0] <= pay_in;
            for (int s = 1; s < NB; s++)
            begin
                dvs_reg[s] <= dvs_reg[s-1];
                pay_reg[s] <= pay_reg[s-1];
            end
            for (int s = 0; s < NB; s++)
            begin
                rem_x_reg[s] <= rem_x_next[s];
                rem_y_reg[s] <= rem_y_next[s];
                quo_x_reg[s] <= quo_x_next[s];
                quo_y_reg[s] <= quo_y_next[s];
            end
        end
    end

    assign out_valid = vld_reg[NB-1];
    assign quo_x     = quo_x_reg[NB-1];
    assign quo_y     = quo_y_reg[NB-1];
    assign pay_out   = pay_reg[NB-1];

endmodule

### rtl/core/vrp_result.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_result
// Applies signs to the quotients, clamps them, packs the result and holds it
// in a two-entry output buffer that also sets the pipeline advance.
// ----------------------------------------------------------------------------
module vrp_result
    import vrp_pkg::*;
#(
    parameter int COORD_WIDTH = 24,
    parameter int NB          = 50
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    input  logic [NB-1:0]                               quo_x,
    input  logic [NB-1:0]                               quo_y,
    input  logic signed [COORD_WIDTH-1:0]               rx,
    input  logic signed [COORD_WIDTH-1:0]               ry,
    input  logic signed [COORD_WIDTH-1:0]               rz,
    input  proj_flags_t                                 flags,
    output logic                                        advance,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    output logic [((5*COORD_WIDTH+7)/8)*8-1:0]          m_tdata,
    output logic [1:0]                                  m_tuser
);

    localparam int W     = COORD_WIDTH;
    localparam int DATAW = ((5 * W + 7) / 8) * 8;
    localparam int ITEMW = 5 * W + 2;

    logic [W-1:0] px, py;
    logic ovf_x, ovf_y;
    logic [ITEMW-1:0] item;
    logic [ITEMW-1:0] buf0_reg, buf1_reg, buf0_next, buf1_next;
    logic [1:0] cnt_reg, cnt_next;
    logic push, pop;

    always_comb
    begin
        // Negative quotients may reach the magnitude of the most negative code.
        if (flags.neg_x)
        begin
            ovf_x = (|quo_x[NB-1:W]) || (quo_x[W-1] && (|quo_x[W-2:0]));
            px    = ovf_x ? {1'b1, {(W-1){1'b0}}} : W'(-quo_x[W-1:0]);
        end
        else
        begin
            ovf_x = |quo_x[NB-1:W-1];
            px    = ovf_x ? {1'b0, {(W-1){1'b1}}} : quo_x[W-1:0];
        end
        if (flags.neg_y)
        begin
            ovf_y = (|quo_y[NB-1:W]) || (quo_y[W-1] && (|quo_y[W-2:0]));
            py    = ovf_y ? {1'b1, {(W-1){1'b0}}} : W'(-quo_y[W-1:0]);
        end
        else
        begin
            ovf_y = |quo_y[NB-1:W-1];
            py    = ovf_y ? {1'b0, {(W-1){1'b1}}} : quo_y[W-1:0];
        end
        if (flags.fault)
        begin
            px    = '0;
            py    = '0;
            ovf_x = 1'b0;
            ovf_y = 1'b0;
        end
        item = {flags.sat | ovf_x | ovf_y, flags.fault, py, px, rz, ry, rx};
    end

    assign advance = !cnt_reg[1];
    assign push    = advance && in_valid;
    assign pop     = (cnt_reg != 2'd0) && m_tready;

    always_comb
    begin
        buf0_next = buf0_reg;
        buf1_next = buf1_reg;
        if (pop)
        begin
            buf0_next = buf1_reg;
        end
        if (push)
        begin
            if ((cnt_reg == 2'd0) || pop)
            begin
                buf0_next = item;
            end
            else
            begin
                buf1_next = item;
            end
        end
        cnt_next = 2'(cnt_reg + {1'b0, push} - {1'b0, pop});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf0_reg <= buf0_next;
        buf1_reg <= buf1_next;
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = DATAW'(buf0_reg[5*W-1:0]);
    assign m_tuser  = buf0_reg[ITEMW-1:5*W];

endmodule

### rtl/core/vrp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrp_checker
// Port-level checks on the vertex rotate and project core, attached by bind.
// ----------------------------------------------------------------------------
module vrp_checker
#(
    parameter int COORD_WIDTH = 24
)
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [((5*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
    input logic [1:0]                         m_tuser
);

    localparam int W = COORD_WIDTH;

    // A stalled result transaction keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output transaction changed while stalled");

    // A zero denominator forces both projections to zero.
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata[3*W +: W] == '0) && (m_tdata[4*W +: W] == '0))
        else $error("projection not zero on divide fault");

    // Input is only refused while the output buffer is full.
    a_refuse_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input refused with no result waiting");

    // Nothing comes out in the first cycle after reset.
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind vertex_rotate_project_core vrp_checker #(.COORD_WIDTH(COORD_WIDTH)) u_vrp_checker (.*);
